// ----- rtl/core/vcrp_pkg.sv -----
// Shared types, codes and the CRC-8 step for the reply parser.
// No dependencies; imported by every module in rtl/core.
`default_nettype none

package vcrp_pkg;

    localparam int STORED_BYTES_DEF = 6;

    localparam int            CFG_IDX_W         = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_SEED      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_ATTEMPTS = 1'b1;
    localparam logic [7:0]    CRC_SEED_RST      = 8'h00;
    localparam logic [3:0]    SYNC_ATTEMPTS_RST = 4'd3;

    localparam logic [7:0] CRC_POLY  = 8'hD5;
    localparam logic [7:0] SYNC_A    = 8'hAA;
    localparam logic [7:0] SYNC_B    = 8'h55;

    localparam logic [7:0] RC_SETTINGS_V1  = 8'h01;
    localparam logic [7:0] RC_SET_POWER    = 8'h02;
    localparam logic [7:0] RC_SET_CHANNEL  = 8'h03;
    localparam logic [7:0] RC_SET_FREQ     = 8'h04;
    localparam logic [7:0] RC_SET_MODE     = 8'h05;
    localparam logic [7:0] RC_SETTINGS_V2  = 8'h09;
    localparam logic [7:0] RC_SETTINGS_V21 = 8'h11;

    localparam logic [1:0] VER_V1  = 2'd1;
    localparam logic [1:0] VER_V2  = 2'd2;
    localparam logic [1:0] VER_V21 = 2'd3;

    localparam logic [7:0] EMB_CHECK_IDX = 8'd5;
    localparam logic [7:0] EMB_MIN_LEN   = 8'd6;

    typedef enum logic [2:0] {
        PH_HUNT_A = 3'd0,
        PH_HUNT_B = 3'd1,
        PH_CODE   = 3'd2,
        PH_LEN    = 3'd3,
        PH_BODY   = 3'd4,
        PH_CHECK  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SYNC = 2'd1,
        ST_BAD_CRC  = 2'd2,
        ST_TIMEOUT  = 2'd3
    } status_t;

    typedef struct packed {
        logic       valid;
        logic       cmd;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic       valid;
        status_t    status;
        logic [7:0] code;
        logic [1:0] version;
        logic [7:0] channel;
        logic [7:0] power;
        logic [7:0] mode;
        logic [15:0] frequency;
        logic [31:0] count;
    } result_t;

    // CRC-8, MSB first
    function automatic logic [7:0] crc_step(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] v;
        v = c ^ b;
        for (int i = 0; i < 8; i++)
        begin
            v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/vcrp_input_stage.sv -----
// Input register for received items.
// Depends on vcrp_pkg (item_t).
`default_nettype none

module vcrp_input_stage
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          cmd,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          take,
    output logic               in_stall,
    output vcrp_pkg::item_t    item
);
    import vcrp_pkg::*;

    logic       valid_reg;
    logic       cmd_reg;
    logic [7:0] data_reg;
    logic       valid_next;
    logic       load;

    assign in_stall = valid_reg && !take;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cmd_reg  <= cmd;
            data_reg <= rx_byte;
        end
    end

    assign item.valid = valid_reg;
    assign item.cmd   = cmd_reg;
    assign item.data  = data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/vcrp_parse_core.sv -----
// Reply parser state machine, CRC, payload store and stored settings.
// Depends on vcrp_pkg (types, codes, crc_step).
`default_nettype none

module vcrp_parse_core
#(
    parameter int STORED_BYTES = vcrp_pkg::STORED_BYTES_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [vcrp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    input  wire vcrp_pkg::item_t               item,
    input  wire logic                          can_load,
    output logic                               take,
    output vcrp_pkg::result_t                  res
);
    import vcrp_pkg::*;

    localparam int IDX_W = $clog2(STORED_BYTES);

    logic [7:0]  crc_seed_reg;
    logic [3:0]  sync_attempts_reg;

    phase_t      phase_reg, phase_next;
    logic [3:0]  failed_reg, failed_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  length_reg, length_next;
    logic [7:0]  idx_reg, idx_next;
    logic [7:0]  pay_reg [STORED_BYTES];
    logic [7:0]  pay_next [STORED_BYTES];
    logic [7:0]  crc_reg, crc_next;
    logic [7:0]  crcb5_reg, crcb5_next;
    logic [1:0]  version_reg, version_next;
    logic [7:0]  channel_reg, channel_next;
    logic [7:0]  power_reg, power_next;
    logic [7:0]  mode_reg, mode_next;
    logic [15:0] freq_reg, freq_next;
    logic [31:0] count_reg, count_next;

    logic        fire;
    logic        tmo;
    logic [7:0]  b;
    logic [7:0]  idx_inc;
    logic        end_body;
    logic        emb;
    logic [7:0]  len_new;
    logic [7:0]  pay5_new;
    logic [7:0]  crcb5_new;
    logic        emb_bad;
    logic        finish_ok;
    logic        finish_bad;
    logic        sync_fail;
    logic [3:0]  fail_cnt;
    logic [3:0]  limit;
    logic        fail_emit;
    logic [8:0]  alt_w;
    logic [7:0]  alt;

    assign take = item.valid && can_load;
    assign fire = take;
    assign tmo  = item.cmd;
    assign b    = item.data;

    // decode
    always_comb
    begin
        idx_inc   = idx_reg + 8'd1;
        end_body  = ((phase_reg == PH_LEN) && (b == 8'd0))
                 || ((phase_reg == PH_BODY) && (idx_inc >= length_reg));
        emb       = (code_reg == RC_SETTINGS_V1) || (code_reg == RC_SETTINGS_V2);
        len_new   = (phase_reg == PH_LEN) ? b : length_reg;
        pay5_new  = ((phase_reg == PH_BODY) && (idx_reg == EMB_CHECK_IDX)) ? b : pay_reg[5];
        crcb5_new = ((phase_reg == PH_BODY) && (idx_reg == EMB_CHECK_IDX)) ? crc_reg : crcb5_reg;
        emb_bad   = (len_new < EMB_MIN_LEN) || (crcb5_new != pay5_new);
        finish_ok  = fire && !tmo
                  && ((end_body && emb && !emb_bad) || ((phase_reg == PH_CHECK) && (b == crc_reg)));
        finish_bad = fire && !tmo
                  && ((end_body && emb && emb_bad) || ((phase_reg == PH_CHECK) && (b != crc_reg)));
        sync_fail = fire && !tmo
                 && (((phase_reg == PH_HUNT_A) && (b != SYNC_A))
                  || ((phase_reg == PH_HUNT_B) && (b != SYNC_B)));
        fail_cnt  = failed_reg + 4'd1;
        limit     = (sync_attempts_reg == 4'd0) ? 4'd1 : sync_attempts_reg;
        fail_emit = sync_fail && ((fail_cnt >= limit) || (fail_cnt == 4'd0));
        alt_w     = 9'(channel_reg[7:3]) * 9'd10 + 9'(channel_reg[2:0]);
        alt       = alt_w[7:0];
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (fire)
        begin
            if (tmo)
            begin
                phase_next = PH_HUNT_A;
            end
            else
            begin
                case (phase_reg)
                    PH_HUNT_A: phase_next = (b == SYNC_A) ? PH_HUNT_B : PH_HUNT_A;
                    PH_HUNT_B: phase_next = (b == SYNC_B) ? PH_CODE : PH_HUNT_A;
                    PH_CODE:   phase_next = PH_LEN;
                    PH_LEN:    phase_next = end_body ? (emb ? PH_HUNT_A : PH_CHECK) : PH_BODY;
                    PH_BODY:   phase_next = end_body ? (emb ? PH_HUNT_A : PH_CHECK) : PH_BODY;
                    PH_CHECK:  phase_next = PH_HUNT_A;
                    default:   phase_next = PH_HUNT_A;
                endcase
            end
        end
    end

    // data path and result
    always_comb
    begin
        failed_next  = failed_reg;
        code_next    = code_reg;
        length_next  = length_reg;
        idx_next     = idx_reg;
        pay_next     = pay_reg;
        crc_next     = crc_reg;
        crcb5_next   = crcb5_reg;
        version_next = version_reg;
        channel_next = channel_reg;
        power_next   = power_reg;
        mode_next    = mode_reg;
        freq_next    = freq_reg;
        count_next   = count_reg;
        res.valid    = 1'b0;
        res.status   = ST_OK;
        res.code     = code_reg;

        if (fire)
        begin
            if (tmo)
            begin
                failed_next = 4'd0;
                res.valid   = 1'b1;
                res.status  = ST_TIMEOUT;
                res.code    = 8'd0;
            end
            else
            begin
                case (phase_reg)
                    PH_HUNT_B:
                    begin
                        if (b == SYNC_B)
                        begin
                            failed_next = 4'd0;
                            for (int i = 0; i < STORED_BYTES; i++)
                            begin
                                pay_next[i] = 8'd0;
                            end
                            crc_next    = crc_seed_reg;
                            crcb5_next  = 8'd0;
                            idx_next    = 8'd0;
                            code_next   = 8'd0;
                            length_next = 8'd0;
                        end
                    end
                    PH_CODE:
                    begin
                        code_next = b;
                        crc_next  = crc_step(crc_reg, b);
                    end
                    PH_LEN:
                    begin
                        length_next = b;
                        crc_next    = crc_step(crc_reg, b);
                        idx_next    = 8'd0;
                    end
                    PH_BODY:
                    begin
                        crcb5_next = crcb5_new;
                        if (idx_reg < 8'(STORED_BYTES))
                        begin
                            pay_next[idx_reg[IDX_W-1:0]] = b;
                        end
                        crc_next = crc_step(crc_reg, b);
                        idx_next = idx_inc;
                    end
                    default:
                    begin
                    end
                endcase

                if (sync_fail)
                begin
                    if (fail_emit)
                    begin
                        failed_next = 4'd0;
                        res.valid   = 1'b1;
                        res.status  = ST_BAD_SYNC;
                        res.code    = 8'd0;
                    end
                    else
                    begin
                        failed_next = fail_cnt;
                    end
                end

                if (finish_bad)
                begin
                    res.valid  = 1'b1;
                    res.status = ST_BAD_CRC;
                end

                if (finish_ok)
                begin
                    // payload bytes 0..4 are already stored when a reply completes; bytes past its length read as zero
                    case (code_reg)
                        RC_SETTINGS_V1, RC_SETTINGS_V2, RC_SETTINGS_V21:
                        begin
                            version_next = (code_reg == RC_SETTINGS_V1) ? VER_V1 :
                                           (code_reg == RC_SETTINGS_V2) ? VER_V2 : VER_V21;
                            channel_next = pay_reg[0];
                            power_next   = pay_reg[1];
                            mode_next    = pay_reg[2];
                            freq_next    = {pay_reg[3], pay_reg[4]};
                        end
                        RC_SET_POWER:
                        begin
                            // arguments may come back swapped
                            if ((pay_reg[0] == channel_reg) || (pay_reg[0] == alt))
                            begin
                                power_next = pay_reg[1];
                            end
                            else if (pay_reg[1] == 8'd1)
                            begin
                                power_next = pay_reg[0];
                            end
                        end
                        RC_SET_CHANNEL: channel_next = pay_reg[0];
                        RC_SET_FREQ:    freq_next    = {pay_reg[0], pay_reg[1]};
                        RC_SET_MODE:    mode_next    = pay_reg[0];
                        default:
                        begin
                        end
                    endcase
                    count_next = count_reg + 32'd1;
                    res.valid  = 1'b1;
                    res.status = ST_OK;
                end
            end
        end

        res.version   = version_next;
        res.channel   = channel_next;
        res.power     = power_next;
        res.mode      = mode_next;
        res.frequency = freq_next;
        res.count     = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_seed_reg      <= CRC_SEED_RST;
            sync_attempts_reg <= SYNC_ATTEMPTS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CRC_SEED:      crc_seed_reg      <= cfg_data;
                CFG_SYNC_ATTEMPTS: sync_attempts_reg <= cfg_data[3:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT_A;
            failed_reg  <= 4'd0;
            code_reg    <= 8'd0;
            length_reg  <= 8'd0;
            idx_reg     <= 8'd0;
            for (int i = 0; i < STORED_BYTES; i++)
            begin
                pay_reg[i] <= 8'd0;
            end
            crc_reg     <= 8'd0;
            crcb5_reg   <= 8'd0;
            version_reg <= 2'd0;
            channel_reg <= 8'd0;
            power_reg   <= 8'd0;
            mode_reg    <= 8'd0;
            freq_reg    <= 16'd0;
            count_reg   <= 32'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            failed_reg  <= failed_next;
            code_reg    <= code_next;
            length_reg  <= length_next;
            idx_reg     <= idx_next;
            pay_reg     <= pay_next;
            crc_reg     <= crc_next;
            crcb5_reg   <= crcb5_next;
            version_reg <= version_next;
            channel_reg <= channel_next;
            power_reg   <= power_next;
            mode_reg    <= mode_next;
            freq_reg    <= freq_next;
            count_reg   <= count_next;
        end
    end

    a_result_ends_reply: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.valid |=> phase_reg == PH_HUNT_A)
        else $error("result issued without returning to sync hunt");

    a_ok_counts: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.valid && (res.status == ST_OK)
        |=> count_reg == $past(count_reg) + 32'd1)
        else $error("accepted reply not counted");

    a_no_result_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !res.valid |=> count_reg == $past(count_reg))
        else $error("reply count moved without a result");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(phase_reg) && $stable(count_reg) && $stable(failed_reg))
        else $error("parser state moved without an item");

endmodule

`default_nettype wire

// ----- rtl/core/vcrp_output_stage.sv -----
// Result register between the parser and the output channel.
// Depends on vcrp_pkg (result_t).
`default_nettype none

module vcrp_output_stage
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              take,
    input  wire vcrp_pkg::result_t res,
    input  wire logic              out_stall,
    output logic                   can_load,
    output logic                   out_valid,
    output vcrp_pkg::result_t      out_res
);
    import vcrp_pkg::*;

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign can_load = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg && out_stall;
        if (take)
        begin
            valid_next = res.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res.valid)
        begin
            data_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/vtx_control_reply_parser_unit.sv -----
// Video transmitter control reply parser: sync hunt, CRC-8 check, settings update.
// An accepted item is held in the input register; the parser result is registered in the output stage.
// Throughput: one item per cycle unless the output stalls; each taken item updates the parser state in a single step.
// An output stall holds the result register and stalls the input once both stages are full.
// Reset (rst_n, async, active low) clears the valid flags and all parser state at once; no clearing pass.
// Depends on vcrp_pkg, vcrp_input_stage, vcrp_parse_core, vcrp_output_stage.
`default_nettype none

module vtx_control_reply_parser_unit
#(
    parameter int STORED_BYTES = vcrp_pkg::STORED_BYTES_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [vcrp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                     cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           cmd,
    input  wire logic [7:0]                     rx_byte,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [1:0]                          status,
    output logic [7:0]                          reply_code,
    output logic [1:0]                          protocol_version,
    output logic [7:0]                          channel_now,
    output logic [7:0]                          power_now,
    output logic [7:0]                          mode_now,
    output logic [15:0]                         frequency_now,
    output logic [31:0]                         replies_ok
);
    import vcrp_pkg::*;

    item_t   item;
    result_t res;
    result_t out_res;
    logic    take;
    logic    can_load;

    vcrp_input_stage u_in
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .rx_byte  (rx_byte),
        .take     (take),
        .in_stall (in_stall),
        .item     (item)
    );

    vcrp_parse_core #(.STORED_BYTES(STORED_BYTES)) u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item),
        .can_load  (can_load),
        .take      (take),
        .res       (res)
    );

    vcrp_output_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .res       (res),
        .out_stall (out_stall),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign status           = out_res.status;
    assign reply_code       = out_res.code;
    assign protocol_version = out_res.version;
    assign channel_now      = out_res.channel;
    assign power_now        = out_res.power;
    assign mode_now         = out_res.mode;
    assign frequency_now    = out_res.frequency;
    assign replies_ok       = out_res.count;

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for vtx_control_reply_parser_unit: replies, noise and timeouts
// are driven over the valid/stall ports, and a scoreboard predicts every status result.
// Depends on vcrp_pkg and the parser RTL only.

module testbench;
    import vcrp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 160;

    typedef struct {
        logic [1:0]  status;
        logic [7:0]  code;
        logic [1:0]  version;
        logic [7:0]  channel;
        logic [7:0]  power;
        logic [7:0]  mode;
        logic [15:0] frequency;
        logic [31:0] count;
    } reply_t;

    class ReplyScoreboard;
        logic [7:0]  crc_seed;
        logic [3:0]  sync_attempts;
        phase_t      ph;
        logic [3:0]  failed_tries;
        logic [7:0]  code_held;
        logic [7:0]  length_held;
        logic [7:0]  byte_index;
        logic [7:0]  payload [STORED_BYTES_DEF];
        logic [7:0]  crc_running;
        logic [7:0]  crc_at_check;
        logic [1:0]  version;
        logic [7:0]  channel;
        logic [7:0]  power;
        logic [7:0]  mode;
        logic [15:0] frequency;
        logic [31:0] accepted;
        reply_t      expected_replies [$];
        int          errors;
        int          items_seen;
        int          results_seen;
        int          status_seen [4];

        function new();
            crc_seed      = CRC_SEED_RST;
            sync_attempts = SYNC_ATTEMPTS_RST;
            ph            = PH_HUNT_A;
            failed_tries  = '0;
            code_held     = '0;
            length_held   = '0;
            byte_index    = '0;
            foreach (payload[i])
                payload[i] = '0;
            crc_running   = '0;
            crc_at_check  = '0;
            version       = '0;
            channel       = '0;
            power         = '0;
            mode          = '0;
            frequency     = '0;
            accepted      = '0;
            errors        = 0;
            items_seen    = 0;
            results_seen  = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        static function logic [7:0] crc8_next(logic [7:0] c, logic [7:0] b);
            logic [7:0] v;
            v = c ^ b;
            repeat (8)
                v = {v[6:0], 1'b0} ^ (v[7] ? CRC_POLY : 8'h00);
            return v;
        endfunction

        function void push_reply(status_t st, logic [7:0] code);
            reply_t r;
            r.status    = st;
            r.code      = code;
            r.version   = version;
            r.channel   = channel;
            r.power     = power;
            r.mode      = mode;
            r.frequency = frequency;
            r.count     = accepted;
            expected_replies.push_back(r);
            ph = PH_HUNT_A;
        endfunction

        function void miss_sync();
            logic [3:0] lim;
            lim = (sync_attempts == 4'd0) ? 4'd1 : sync_attempts;
            ph = PH_HUNT_A;
            failed_tries = failed_tries + 4'd1;
            if (failed_tries >= lim || failed_tries == 4'd0)
            begin
                failed_tries = '0;
                push_reply(ST_BAD_SYNC, 8'h00);
            end
        endfunction

        function void apply_reply();
            int alt;
            case (code_held)
                RC_SETTINGS_V1, RC_SETTINGS_V2, RC_SETTINGS_V21:
                begin
                    if (code_held == RC_SETTINGS_V1)
                        version = VER_V1;
                    else if (code_held == RC_SETTINGS_V2)
                        version = VER_V2;
                    else
                        version = VER_V21;
                    channel   = payload[0];
                    power     = payload[1];
                    mode      = payload[2];
                    frequency = {payload[3], payload[4]};
                end
                RC_SET_POWER:
                begin
                    // power workaround: arguments may come back swapped
                    alt = (int'(channel) / 8) * 10 + int'(channel) % 8;
                    if (payload[0] == channel || payload[0] == alt[7:0])
                        power = payload[1];
                    else if (payload[1] == 8'd1)
                        power = payload[0];
                end
                RC_SET_CHANNEL:
                    channel = payload[0];
                RC_SET_FREQ:
                    frequency = {payload[0], payload[1]};
                RC_SET_MODE:
                    mode = payload[0];
                default:
                    ;
            endcase
            accepted = accepted + 32'd1;
        endfunction

        function void end_of_body();
            if (code_held != RC_SETTINGS_V1 && code_held != RC_SETTINGS_V2)
                ph = PH_CHECK;
            else if (length_held < EMB_MIN_LEN || crc_at_check != payload[EMB_CHECK_IDX])
                push_reply(ST_BAD_CRC, code_held);
            else
            begin
                apply_reply();
                push_reply(ST_OK, code_held);
            end
        endfunction

        function void note_item(logic is_timeout, logic [7:0] b);
            items_seen++;
            if (is_timeout)
            begin
                failed_tries = '0;
                push_reply(ST_TIMEOUT, 8'h00);
                return;
            end
            case (ph)
                PH_HUNT_A:
                    if (b == SYNC_A)
                        ph = PH_HUNT_B;
                    else
                        miss_sync();
                PH_HUNT_B:
                    if (b != SYNC_B)
                        miss_sync();
                    else
                    begin
                        failed_tries = '0;
                        foreach (payload[i])
                            payload[i] = '0;
                        crc_running  = crc_seed;
                        crc_at_check = '0;
                        byte_index   = '0;
                        code_held    = '0;
                        length_held  = '0;
                        ph           = PH_CODE;
                    end
                PH_CODE:
                begin
                    code_held   = b;
                    crc_running = crc8_next(crc_running, b);
                    ph          = PH_LEN;
                end
                PH_LEN:
                begin
                    length_held = b;
                    crc_running = crc8_next(crc_running, b);
                    byte_index  = '0;
                    if (length_held == 8'd0)
                        end_of_body();
                    else
                        ph = PH_BODY;
                end
                PH_BODY:
                begin
                    if (byte_index == EMB_CHECK_IDX)
                        crc_at_check = crc_running;
                    if (byte_index < STORED_BYTES_DEF)
                        payload[byte_index] = b;
                    crc_running = crc8_next(crc_running, b);
                    byte_index  = byte_index + 8'd1;
                    if (byte_index >= length_held)
                        end_of_body();
                end
                PH_CHECK:
                    if (b != crc_running)
                        push_reply(ST_BAD_CRC, code_held);
                    else
                    begin
                        apply_reply();
                        push_reply(ST_OK, code_held);
                    end
                default:
                    ph = PH_HUNT_A;
            endcase
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        task check_result(reply_t got);
            reply_t want;
            results_seen++;
            status_seen[got.status]++;
            if (expected_replies.size() == 0)
            begin
                report($sformatf("result with nothing pending, status %0d", got.status));
                return;
            end
            want = expected_replies.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.code !== want.code)
                report($sformatf("reply_code %02h, want %02h", got.code, want.code));
            if (got.version !== want.version)
                report($sformatf("version %0d, want %0d", got.version, want.version));
            if (got.channel !== want.channel)
                report($sformatf("channel %02h, want %02h", got.channel, want.channel));
            if (got.power !== want.power)
                report($sformatf("power %02h, want %02h", got.power, want.power));
            if (got.mode !== want.mode)
                report($sformatf("mode %02h, want %02h", got.mode, want.mode));
            if (got.frequency !== want.frequency)
                report($sformatf("frequency %04h, want %04h", got.frequency, want.frequency));
            if (got.count !== want.count)
                report($sformatf("replies_ok %0d, want %0d", got.count, want.count));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic                 cmd;
    logic [7:0]           rx_byte;
    logic                 out_valid;
    logic                 out_stall;
    logic [1:0]           status;
    logic [7:0]           reply_code;
    logic [1:0]           protocol_version;
    logic [7:0]           channel_now;
    logic [7:0]           power_now;
    logic [7:0]           mode_now;
    logic [15:0]          frequency_now;
    logic [31:0]          replies_ok;

    ReplyScoreboard sb;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  hold_req = 1'b0;
    int  cycle_count = 0;

    vtx_control_reply_parser_unit dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .cmd              (cmd),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .reply_code       (reply_code),
        .protocol_version (protocol_version),
        .channel_now      (channel_now),
        .power_now        (power_now),
        .mode_now         (mode_now),
        .frequency_now    (frequency_now),
        .replies_ok       (replies_ok)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("vtx_control_reply_parser_unit test failed");
            $finish;
        end
    end

    // receiver: random stall, plus a long hold-off counted here
    initial
    begin : receiver
        int hold_left;
        bit armed;
        hold_left = 0;
        armed     = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !armed)
            begin
                armed     = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (!hold_req)
                armed = 1'b0;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        reply_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.status    = status;
            got.code      = reply_code;
            got.version   = protocol_version;
            got.channel   = channel_now;
            got.power     = power_now;
            got.mode      = mode_now;
            got.frequency = frequency_now;
            got.count     = replies_ok;
            sb.check_result(got);
        end
    end

    task automatic send_item(logic is_timeout, logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= is_timeout;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(is_timeout, b);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.expected_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_config(logic [7:0] seed, logic [7:0] attempts);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CRC_SEED;
        cfg_data  <= seed;
        @(posedge clk);
        cfg_index <= CFG_SYNC_ATTEMPTS;
        cfg_data  <= attempts;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.crc_seed      = seed;
        sb.sync_attempts = attempts[3:0];
    endtask

    // abort_at < 0: no timeout inside the reply
    task automatic send_packet(logic [7:0] code, int len, bit corrupt, int abort_at);
        logic [7:0] bytes [$];
        logic [7:0] crc;
        logic [7:0] p;
        int         alt;
        bit         embedded;
        embedded = (code == RC_SETTINGS_V1 || code == RC_SETTINGS_V2);
        bytes.push_back(SYNC_A);
        bytes.push_back(SYNC_B);
        bytes.push_back(code);
        bytes.push_back(len[7:0]);
        crc = ReplyScoreboard::crc8_next(sb.crc_seed, code);
        crc = ReplyScoreboard::crc8_next(crc, len[7:0]);
        for (int i = 0; i < len; i++)
        begin
            p = 8'($urandom_range(0, 255));
            if (code == RC_SET_POWER && i == 0)
            begin
                alt = (int'(sb.channel) / 8) * 10 + int'(sb.channel) % 8;
                case ($urandom_range(0, 2))
                    0: p = sb.channel;
                    1: p = alt[7:0];
                    default: ;
                endcase
            end
            if (code == RC_SET_POWER && i == 1 && $urandom_range(0, 2) == 0)
                p = 8'd1;
            if (embedded && i == EMB_CHECK_IDX)
                p = corrupt ? crc ^ (8'd1 << $urandom_range(0, 7)) : crc;
            bytes.push_back(p);
            crc = ReplyScoreboard::crc8_next(crc, p);
        end
        if (!embedded)
            bytes.push_back(corrupt ? crc ^ (8'd1 << $urandom_range(0, 7)) : crc);
        foreach (bytes[k])
        begin
            if (k == abort_at)
            begin
                send_item(1'b1, 8'($urandom_range(0, 255)));
                break;
            end
            send_item(1'b0, bytes[k]);
        end
    endtask

    task automatic send_random_unit();
        int         r;
        int         len;
        logic [7:0] code;
        logic [7:0] b;
        r = $urandom_range(0, 99);
        if (r < 6)
            send_item(1'b1, 8'($urandom_range(0, 255)));
        else if (r < 16)
        begin
            repeat ($urandom_range(1, 5))
                send_item(1'b0, 8'($urandom_range(0, 255)));
        end
        else if (r < 21)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == SYNC_B)
                b = ~b;
            send_item(1'b0, SYNC_A);
            send_item(1'b0, b);
        end
        else
        begin
            case ($urandom_range(0, 9))
                0: code = RC_SETTINGS_V1;
                1: code = RC_SETTINGS_V2;
                2: code = RC_SETTINGS_V21;
                3: code = RC_SET_POWER;
                4: code = RC_SET_CHANNEL;
                5: code = RC_SET_FREQ;
                6: code = RC_SET_MODE;
                default: code = 8'($urandom_range(0, 255));
            endcase
            r = $urandom_range(0, 99);
            if (code == RC_SETTINGS_V1 || code == RC_SETTINGS_V2)
                len = (r < 15) ? $urandom_range(0, 5) : (r < 85) ? 6 : $urandom_range(7, 12);
            else
                len = (r < 95) ? $urandom_range(0, 8) : $urandom_range(9, 24);
            send_packet(code, len, $urandom_range(0, 99) < 10,
                        ($urandom_range(0, 99) < 5) ? $urandom_range(0, len + 4) : -1);
        end
    endtask

    task automatic run_phase(logic [7:0] seed, logic [7:0] attempts, int idle, int stall);
        int stop_at;
        wait_idle();
        write_config(seed, attempts);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        stop_at = sb.items_seen + PHASE_ITEMS;
        while (sb.items_seen < stop_at)
            send_random_unit();
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        cmd       = 1'b0;
        rx_byte   = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: timeout while hunting, sync misses up to the limit,
        // settings with all-ones payload, short settings, timeout mid-reply, bad CRC
        send_item(1'b1, 8'hFF);
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, SYNC_A);
        send_item(1'b0, 8'h00);
        send_item(1'b0, SYNC_A);
        send_item(1'b0, SYNC_B);
        send_item(1'b0, RC_SETTINGS_V2);
        send_item(1'b0, 8'd6);
        repeat (5) send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h3C);
        send_packet(RC_SETTINGS_V1, 0, 1'b0, -1);
        send_packet(RC_SET_CHANNEL, 1, 1'b0, 3);
        send_packet(RC_SET_MODE, 1, 1'b1, -1);

        run_phase(8'h00, 8'h01, 0, 0);
        run_phase(8'hFF, 8'h0F, 73, 0);
        run_phase(8'($urandom_range(0, 255)), {4'($urandom_range(0, 15)), 4'd0}, 0, 73);
        run_phase(8'($urandom_range(0, 255)), 8'($urandom_range(1, 15)), 37, 37);
        run_phase(8'($urandom_range(0, 255)), 8'h03, 0, 0);

        // long receiver hold-off with the sender still pushing items
        wait_idle();
        write_config(8'($urandom_range(0, 255)), 8'h01);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
        repeat (24) send_item(1'b0, 8'h00);
        repeat (3) send_packet(RC_SETTINGS_V21, 6, 1'b0, -1);
        hold_req = 1'b0;

        wait_idle();
        $display("Summary: %0d items driven, %0d results checked", sb.items_seen,
                 sb.results_seen);
        $display("Summary: accepted %0d, bad sync %0d, bad crc %0d, timeout %0d",
                 sb.status_seen[ST_OK], sb.status_seen[ST_BAD_SYNC],
                 sb.status_seen[ST_BAD_CRC], sb.status_seen[ST_TIMEOUT]);
        if (sb.errors == 0)
            $display("vtx_control_reply_parser_unit test passed");
        else
            $display("vtx_control_reply_parser_unit test failed");
        $finish;
    end
endmodule
